@@ design/assert_macros.svh @@
// assertion macros shared by the receiver rtl
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define ASSERT_IMPLY(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLY(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

@@ design/ahfr_pkg.sv @@
// types, constants and helpers for the ascii hex frame receiver
// no dependencies
`timescale 1ns / 1ps

package ahfr_pkg;

    // default frame lengths and buffer depth
    localparam int STATUS_FRAME_LEN_DEF    = 81;
    localparam int CONFIG_FRAME_LEN_DEF    = 75;
    localparam int TELEMETRY_FRAME_LEN_DEF = 55;
    localparam int HANDSHAKE_FRAME_LEN_DEF = 11;
    localparam int BUF_DEPTH_DEF           = 128;

    // frame lengths never exceed 127, buffer index never exceeds 255
    localparam int LEN_W = 7;
    localparam int IDX_W = 8;

    localparam logic [15:0] TIMEOUT_RESET = 16'd200;

    // start characters
    localparam logic [7:0] CHAR_R = 8'h52;
    localparam logic [7:0] CHAR_Z = 8'h5A;
    localparam logic [7:0] CHAR_X = 8'h58;

    // length field value that marks a config frame
    localparam logic [15:0] CONFIG_LEN_CODE = 16'h0020;
    localparam logic [7:0]  BREW_ON         = 8'h01;

    // index of the second char of each hex pair of interest
    localparam logic [IDX_W-1:0] POS_LEN_HI   = 8'd6;   // length field high byte
    localparam logic [IDX_W-1:0] POS_LEN_LO   = 8'd8;   // length field low byte
    localparam logic [IDX_W-1:0] POS_SET_HI   = 8'd24;  // config payload byte 7
    localparam logic [IDX_W-1:0] POS_SET_LO   = 8'd26;  // config payload byte 8
    localparam logic [IDX_W-1:0] POS_BREW     = 8'd44;  // status payload byte 17
    localparam logic [IDX_W-1:0] POS_BOILER   = 8'd64;  // status payload byte 27
    localparam logic [IDX_W-1:0] POS_STEMP_HI = 8'd66;  // status payload byte 28
    localparam logic [IDX_W-1:0] POS_STEMP_LO = 8'd68;  // status payload byte 29
    localparam logic [IDX_W-1:0] POS_SHOT     = 8'd35;  // telemetry pair 14
    localparam logic [IDX_W-1:0] POS_ZTEMP_HI = 8'd47;  // telemetry chars 46..47
    localparam logic [IDX_W-1:0] POS_ZTEMP_LO = 8'd49;  // telemetry chars 48..49

    typedef enum logic [1:0] {
        HEAD_R,
        HEAD_Z,
        HEAD_X
    } head_t;

    typedef enum logic [2:0] {
        KIND_STATUS    = 3'd0,
        KIND_CONFIG    = 3'd1,
        KIND_SHOT      = 3'd2,
        KIND_HANDSHAKE = 3'd3,
        KIND_CKSUM_ERR = 3'd4
    } kind_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } req_beat_t;

    typedef struct packed {
        kind_t       frame_kind;
        logic        brew_active;
        logic [7:0]  boiler_flags;
        logic [15:0] temp_raw;
        logic [15:0] setpoint_raw;
        logic        shot_active;
        logic        handshake_seen;
    } rsp_beat_t;

    // one stored byte on its way to the decoder
    typedef struct packed {
        head_t            head;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        logic             complete;
    } stage_beat_t;

    // decoder feedback to the front end
    typedef struct packed {
        logic retarget;
        logic emit;
    } dec_ctrl_t;

    // ascii hex digit value, anything else reads as zero
    function automatic logic [3:0] nibble(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

@@ design/ahfr_decode.sv @@
// payload decoder: hex pairs, running checksum, field capture and result build
// depends on ahfr_pkg
`timescale 1ns / 1ps

module ahfr_decode
    import ahfr_pkg::*;
#(
    parameter int CONFIG_FRAME_LEN = CONFIG_FRAME_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  stage_beat_t beat,
    input  logic [7:0]  prev_byte,
    output dec_ctrl_t   ctrl,
    output rsp_beat_t   result
);

    logic [7:0]  acc_reg, acc_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic        brew_reg, brew_next;
    logic [7:0]  boiler_reg, boiler_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] setpoint_reg, setpoint_next;
    logic        shot_reg, shot_next;
    logic        hs_reg, hs_next;
    logic [7:0]  pair_now;
    logic        sum_ok;

    // hex pair ending at this beat, running sum and field capture
    always_comb
    begin
        pair_now      = {nibble(prev_byte), nibble(beat.data)};
        acc_next      = (beat.idx == '0) ? beat.data : acc_reg + beat.data;
        len_hi_next   = len_hi_reg;
        brew_next     = brew_reg;
        boiler_next   = boiler_reg;
        temp_next     = temp_reg;
        setpoint_next = setpoint_reg;
        shot_next     = shot_reg;
        hs_next       = hs_reg;
        if (beat.head == HEAD_R)
        begin
            if (beat.idx == POS_LEN_HI)   len_hi_next = pair_now;
            if (beat.idx == POS_SET_HI)   setpoint_next[15:8] = pair_now;
            if (beat.idx == POS_SET_LO)   setpoint_next[7:0] = pair_now;
            if (beat.idx == POS_BREW)     brew_next = (pair_now == BREW_ON);
            if (beat.idx == POS_BOILER)   boiler_next = pair_now;
            if (beat.idx == POS_STEMP_HI) temp_next[15:8] = pair_now;
            if (beat.idx == POS_STEMP_LO) temp_next[7:0] = pair_now;
        end
        if (beat.head == HEAD_Z)
        begin
            if (beat.idx == POS_SHOT)     shot_next = (pair_now != 8'h00);
            if (beat.idx == POS_ZTEMP_HI) temp_next[15:8] = pair_now;
            if (beat.idx == POS_ZTEMP_LO) temp_next[7:0] = pair_now;
        end
        if (beat.complete && beat.head == HEAD_X)
        begin
            hs_next = 1'b1;
        end
    end

    // sum of all chars before the trailing pair against that pair
    assign sum_ok = ((acc_reg - prev_byte) == pair_now);

    // feedback to the front end
    always_comb
    begin
        ctrl.emit     = advance && beat.complete;
        ctrl.retarget = advance && beat.head == HEAD_R && beat.idx == POS_LEN_LO
                        && {len_hi_reg, pair_now} == CONFIG_LEN_CODE;
    end

    // result of a completed frame
    always_comb
    begin
        result = '0;
        result.handshake_seen = hs_next;
        case (beat.head)
            HEAD_R:
            begin
                if (!sum_ok)
                begin
                    result.frame_kind = KIND_CKSUM_ERR;
                end
                else if ((beat.idx + 8'd1) == IDX_W'(CONFIG_FRAME_LEN))
                begin
                    result.frame_kind   = KIND_CONFIG;
                    result.setpoint_raw = setpoint_next;
                end
                else
                begin
                    result.frame_kind   = KIND_STATUS;
                    result.brew_active  = brew_next;
                    result.boiler_flags = boiler_next;
                    result.temp_raw     = temp_next;
                end
            end
            HEAD_Z:
            begin
                result.frame_kind  = KIND_SHOT;
                result.temp_raw    = temp_next;
                result.shot_active = shot_next;
            end
            default:
            begin
                result.frame_kind = KIND_HANDSHAKE;
            end
        endcase
    end

    // field registers, loaded as each beat leaves the stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            acc_reg      <= acc_next;
            len_hi_reg   <= len_hi_next;
            brew_reg     <= brew_next;
            boiler_reg   <= boiler_next;
            temp_reg     <= temp_next;
            setpoint_reg <= setpoint_next;
            shot_reg     <= shot_next;
        end
    end

    // handshake flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg <= 1'b0;
        end
        else if (advance)
        begin
            hs_reg <= hs_next;
        end
    end

endmodule

@@ design/ascii_hex_frame_receiver.sv @@
// ascii hex frame receiver: framing front end, frame buffer and result register
// depends on ahfr_pkg, ahfr_decode and assert_macros.svh
`timescale 1ns / 1ps
//
// usage
//   req channel (valid/ready): each beat is a received uart byte (req_type 0)
//   or a one millisecond tick (req_type 1). 'R', 'Z' and 'X' always open a
//   fresh frame; bytes outside a frame are dropped but clear the idle count.
//   rsp channel (valid/ready): one beat per completed frame, none for a frame
//   lost to timeout or buffer overflow.
//   cfg_we/cfg_wdata write the idle timeout in ticks; write it only while idle.
// timing
//   one req beat per cycle sustained unless the decode stage stalls. a byte is
//   stored in the frame buffer in the cycle it is taken and decoded the next
//   cycle, where its hex pair is built from the previous char read back from
//   the buffer (one read port, registered read). the result of a frame shows
//   on rsp from the result register, loaded as its last byte leaves decode.
// reset and stalls
//   reset clears framing, idle count, handshake flag and rsp valid; the timeout
//   returns to 200. the buffer is not cleared, since only entries of the
//   current frame are read. with a result held on rsp, bytes still pass the
//   decode stage; a beat completing a second frame holds req_ready low.

`include "assert_macros.svh"

module ascii_hex_frame_receiver
    import ahfr_pkg::*;
#(
    parameter int STATUS_FRAME_LEN    = STATUS_FRAME_LEN_DEF,
    parameter int CONFIG_FRAME_LEN    = CONFIG_FRAME_LEN_DEF,
    parameter int TELEMETRY_FRAME_LEN = TELEMETRY_FRAME_LEN_DEF,
    parameter int HANDSHAKE_FRAME_LEN = HANDSHAKE_FRAME_LEN_DEF,
    parameter int BUF_DEPTH           = BUF_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_beat_t   req_data,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_beat_t   rsp_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int FILL_W = $clog2(BUF_DEPTH);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              inside_reg, inside_next;
    logic [LEN_W-1:0]  target_reg, target_next;
    head_t             head_reg, head_next;
    logic [15:0]       idle_reg, idle_next;
    logic [15:0]       timeout_reg;
    logic              s1_valid_reg, s1_valid_next;
    stage_beat_t       s1_reg, s1_next;
    logic              rsp_valid_reg;
    rsp_beat_t         rsp_data_reg;

    logic [7:0]        frame_mem [BUF_DEPTH];
    logic [7:0]        prev_q;
    logic              mem_we, mem_re;
    logic [FILL_W-1:0] base_fill, new_fill, raddr;

    logic              take_byte, take_tick, is_start, live, room, done, s1_go;
    logic [16:0]       idle_inc;
    logic [LEN_W-1:0]  start_len, target_eff;
    head_t             start_head, head_eff;
    dec_ctrl_t         dec_ctrl;
    rsp_beat_t         dec_result;

    // decode stage moves on unless it would overwrite a waiting result
    assign s1_go     = !s1_reg.complete || !rsp_valid_reg || rsp_ready;
    assign req_ready = !s1_valid_reg || s1_go;
    assign take_byte = req_valid && req_ready && !req_data.req_type;
    assign take_tick = req_valid && req_ready && req_data.req_type;

    // start character decode
    always_comb
    begin
        is_start   = 1'b1;
        start_len  = LEN_W'(HANDSHAKE_FRAME_LEN);
        start_head = HEAD_X;
        unique case (req_data.rx_byte)
            CHAR_R:
            begin
                start_len  = LEN_W'(STATUS_FRAME_LEN);
                start_head = HEAD_R;
            end
            CHAR_Z:
            begin
                start_len  = LEN_W'(TELEMETRY_FRAME_LEN);
                start_head = HEAD_Z;
            end
            CHAR_X:
            begin
                start_len  = LEN_W'(HANDSHAKE_FRAME_LEN);
                start_head = HEAD_X;
            end
            default:
            begin
                is_start = 1'b0;
            end
        endcase
    end

    // buffer position, frame length (with retarget forwarded from decode)
    always_comb
    begin
        base_fill  = is_start ? '0 : fill_reg;
        live       = is_start || inside_reg;
        room       = base_fill < FILL_W'(BUF_DEPTH - 1);
        new_fill   = base_fill + 1'b1;
        raddr      = base_fill - 1'b1;
        head_eff   = is_start ? start_head : head_reg;
        target_eff = is_start ? start_len
                   : (dec_ctrl.retarget ? LEN_W'(CONFIG_FRAME_LEN) : target_reg);
        done       = (new_fill == FILL_W'(target_eff));
        mem_we     = take_byte && live && room;
        mem_re     = mem_we && (base_fill != '0);
        idle_inc   = {1'b0, idle_reg} + 17'd1;
    end

    // framing state
    always_comb
    begin
        fill_next   = fill_reg;
        inside_next = inside_reg;
        target_next = dec_ctrl.retarget ? LEN_W'(CONFIG_FRAME_LEN) : target_reg;
        head_next   = head_reg;
        idle_next   = idle_reg;
        if (take_tick)
        begin
            idle_next = idle_inc[16] ? 16'hFFFF : idle_inc[15:0];
            if (inside_reg && idle_inc > {1'b0, timeout_reg})
            begin
                fill_next   = '0;
                inside_next = 1'b0;
                target_next = '0;
            end
        end
        if (take_byte)
        begin
            idle_next = '0;
            if (live)
            begin
                if (room && !done)
                begin
                    fill_next   = new_fill;
                    inside_next = 1'b1;
                    target_next = target_eff;
                    head_next   = head_eff;
                end
                else
                begin
                    fill_next   = '0;
                    inside_next = 1'b0;
                    target_next = '0;
                end
            end
        end
    end

    // decode stage load
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (req_ready)
        begin
            s1_valid_next = mem_we;
            s1_next.head     = head_eff;
            s1_next.idx      = IDX_W'(base_fill);
            s1_next.data     = req_data.rx_byte;
            s1_next.complete = mem_we && done;
        end
    end

    // frame buffer: write this char, read back the one before it
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[base_fill] <= req_data.rx_byte;
        end
        if (mem_re)
        begin
            prev_q <= frame_mem[raddr];
        end
    end

    ahfr_decode #(
        .CONFIG_FRAME_LEN (CONFIG_FRAME_LEN)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_valid_reg && s1_go),
        .beat      (s1_reg),
        .prev_byte (prev_q),
        .ctrl      (dec_ctrl),
        .result    (dec_result)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            inside_reg    <= 1'b0;
            target_reg    <= '0;
            head_reg      <= HEAD_X;
            idle_reg      <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            inside_reg   <= inside_next;
            target_reg   <= target_next;
            head_reg     <= head_next;
            idle_reg     <= idle_next;
            s1_valid_reg <= s1_valid_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (dec_ctrl.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        if (dec_ctrl.emit)
        begin
            rsp_data_reg <= dec_result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // checks
    `ASSERT_IMPLY(a_empty_outside, !inside_reg |-> (fill_reg == '0), "fill count outside a frame")
    `ASSERT_NEVER(a_no_overwrite, dec_ctrl.emit && rsp_valid_reg && !rsp_ready, "result overwritten")
    `ASSERT_IMPLY(a_stall_hold, s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_reg), "decode beat lost in stall")

endmodule
